FILE: rtl/gxl_pkg.sv
package gxl_pkg;

    localparam int unsigned TableBase = 182;

    typedef enum logic [4:0] {
        PEND_NONE = 5'b00001,
        PEND_UM   = 5'b00010,
        PEND_UN   = 5'b00100,
        PEND_LM   = 5'b01000,
        PEND_LN   = 5'b10000
    } pend_t;

    typedef struct packed {
        logic [1:0] len;
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
    } xl_entry_t;

    typedef struct packed {
        logic [3:0][7:0] chars;   // chars[0] goes out first
        logic [2:0]      cnt;
    } xl_group_t;

    function automatic xl_entry_t xl_lookup(input logic [6:0] idx);
        xl_entry_t e;
        case (idx)
            7'd0:    e = {2'd2, "'A", 8'd0};
            7'd2:    e = {2'd2, "'E", 8'd0};
            7'd3:    e = {2'd2, "'H", 8'd0};
            7'd4:    e = {2'd2, "'I", 8'd0};
            7'd6:    e = {2'd2, "'O", 8'd0};
            7'd8:    e = {2'd2, "'Y", 8'd0};
            7'd9:    e = {2'd2, "'W", 8'd0};
            7'd10:   e = {2'd3, "i'\""};
            7'd11:   e = {2'd1, "A", 16'd0};
            7'd12:   e = {2'd1, "V", 16'd0};
            7'd13:   e = {2'd1, "G", 16'd0};
            7'd14:   e = {2'd1, "D", 16'd0};
            7'd15:   e = {2'd1, "E", 16'd0};
            7'd16:   e = {2'd1, "Z", 16'd0};
            7'd17:   e = {2'd1, "H", 16'd0};
            7'd18:   e = {2'd1, "8", 16'd0};
            7'd19:   e = {2'd1, "I", 16'd0};
            7'd20:   e = {2'd1, "K", 16'd0};
            7'd21:   e = {2'd1, "L", 16'd0};
            7'd22:   e = {2'd1, "M", 16'd0};
            7'd23:   e = {2'd1, "N", 16'd0};
            7'd24:   e = {2'd2, "KS", 8'd0};
            7'd25:   e = {2'd1, "O", 16'd0};
            7'd26:   e = {2'd1, "P", 16'd0};
            7'd27:   e = {2'd1, "R", 16'd0};
            7'd29:   e = {2'd1, "S", 16'd0};
            7'd30:   e = {2'd1, "T", 16'd0};
            7'd31:   e = {2'd1, "Y", 16'd0};
            7'd32:   e = {2'd1, "F", 16'd0};
            7'd33:   e = {2'd1, "X", 16'd0};
            7'd34:   e = {2'd2, "PS", 8'd0};
            7'd35:   e = {2'd1, "W", 16'd0};
            7'd36:   e = {2'd2, "I\"", 8'd0};
            7'd37:   e = {2'd2, "Y\"", 8'd0};
            7'd38:   e = {2'd2, "a'", 8'd0};
            7'd39:   e = {2'd2, "e'", 8'd0};
            7'd40:   e = {2'd2, "h'", 8'd0};
            7'd41:   e = {2'd2, "i'", 8'd0};
            7'd42:   e = {2'd3, "y'\""};
            7'd43:   e = {2'd1, "a", 16'd0};
            7'd44:   e = {2'd1, "v", 16'd0};
            7'd45:   e = {2'd1, "g", 16'd0};
            7'd46:   e = {2'd1, "d", 16'd0};
            7'd47:   e = {2'd1, "e", 16'd0};
            7'd48:   e = {2'd1, "z", 16'd0};
            7'd49:   e = {2'd1, "h", 16'd0};
            7'd50:   e = {2'd1, "8", 16'd0};
            7'd51:   e = {2'd1, "i", 16'd0};
            7'd52:   e = {2'd1, "k", 16'd0};
            7'd53:   e = {2'd1, "l", 16'd0};
            7'd54:   e = {2'd1, "m", 16'd0};
            7'd55:   e = {2'd1, "n", 16'd0};
            7'd56:   e = {2'd2, "ks", 8'd0};
            7'd57:   e = {2'd1, "o", 16'd0};
            7'd58:   e = {2'd1, "p", 16'd0};
            7'd59:   e = {2'd1, "r", 16'd0};
            7'd60:   e = {2'd1, "s", 16'd0};
            7'd61:   e = {2'd1, "s", 16'd0};
            7'd62:   e = {2'd1, "t", 16'd0};
            7'd63:   e = {2'd1, "y", 16'd0};
            7'd64:   e = {2'd1, "f", 16'd0};
            7'd65:   e = {2'd1, "x", 16'd0};
            7'd66:   e = {2'd2, "ps", 8'd0};
            7'd67:   e = {2'd1, "w", 16'd0};
            7'd68:   e = {2'd2, "i\"", 8'd0};
            7'd69:   e = {2'd2, "y\"", 8'd0};
            7'd70:   e = {2'd2, "o'", 8'd0};
            7'd71:   e = {2'd2, "y'", 8'd0};
            7'd72:   e = {2'd2, "w'", 8'd0};
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

FILE: rtl/gxl_decode.sv
module gxl_decode
(
    input  logic            [7:0] in_byte,
    input  logic                  eos,
    input  gxl_pkg::pend_t        pend,
    output gxl_pkg::xl_group_t    grp,
    output gxl_pkg::pend_t        pend_next
);
    import gxl_pkg::*;

    logic [7:0]      held_char;
    logic [6:0]      tidx;
    xl_entry_t       ent;
    logic            is_pass;
    logic            is_pi;
    logic            is_tau;
    pend_t           f_pend;
    logic [1:0]      f_cnt;
    logic [2:0][7:0] f_chars;

    always_comb
    begin
        case (pend)
            PEND_UM: held_char = "M";
            PEND_UN: held_char = "N";
            PEND_LM: held_char = "m";
            PEND_LN: held_char = "n";
            default: held_char = 8'd0;
        endcase
    end

    assign tidx    = 7'(in_byte - 8'(TableBase));
    assign ent     = xl_lookup(tidx);
    assign is_pass = (in_byte < 8'(TableBase)) || (in_byte == 8'd183) || (in_byte == 8'd187)
                     || (in_byte == 8'd189) || (in_byte == 8'd210) || (in_byte == 8'd255);
    assign is_pi   = (in_byte == 8'd208) || (in_byte == 8'd240);
    assign is_tau  = (in_byte == 8'd212) || (in_byte == 8'd244);

    // handling of a byte with nothing held
    always_comb
    begin
        f_pend  = PEND_NONE;
        f_cnt   = 2'd0;
        f_chars = '0;
        case (in_byte)
            8'd204:  f_pend = PEND_UM;
            8'd205:  f_pend = PEND_UN;
            8'd236:  f_pend = PEND_LM;
            8'd237:  f_pend = PEND_LN;
            default:
            begin
                if (is_pass)
                begin
                    f_cnt      = 2'd1;
                    f_chars[0] = in_byte;
                end
                else
                begin
                    f_cnt   = ent.len;
                    f_chars = {ent.c2, ent.c1, ent.c0};
                end
            end
        endcase
    end

    always_comb
    begin
        grp       = '0;
        pend_next = PEND_NONE;
        if (eos)
        begin
            grp.chars[0] = held_char;
            grp.cnt      = (pend != PEND_NONE) ? 3'd1 : 3'd0;
        end
        else if (pend == PEND_NONE)
        begin
            grp.chars[2:0] = f_chars;
            grp.cnt        = {1'b0, f_cnt};
            pend_next      = f_pend;
        end
        else if (pend == PEND_UM && is_pi)
        begin
            grp.chars[0] = "B";
            grp.cnt      = 3'd1;
        end
        else if (pend == PEND_LM && is_pi)
        begin
            grp.chars[0] = "b";
            grp.cnt      = 3'd1;
        end
        else if (pend == PEND_UN && is_tau)
        begin
            grp.chars[0] = "D";
            grp.cnt      = 3'd1;
        end
        else if (pend == PEND_LN && is_tau)
        begin
            grp.chars[0] = "d";
            grp.cnt      = 3'd1;
        end
        else
        begin
            grp.chars[0]   = held_char;
            grp.chars[3:1] = f_chars;
            grp.cnt        = 3'd1 + {1'b0, f_cnt};
            pend_next      = f_pend;
        end
    end

endmodule

FILE: rtl/gxl_out.sv
module gxl_out
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  gxl_pkg::xl_group_t grp,
    output logic               free,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic         [7:0] m_tdata,   // out_char
    output logic               m_tlast    // last
);
    import gxl_pkg::*;

    logic [3:0][7:0] chars_reg;
    logic [3:0][7:0] chars_next;
    logic [2:0]      rem_reg;
    logic [2:0]      rem_next;
    logic            xfer;

    assign m_tvalid = (rem_reg != 3'd0);
    assign m_tlast  = (rem_reg == 3'd1);
    assign m_tdata  = chars_reg[0];
    assign xfer     = m_tvalid && m_tready;
    assign free     = !m_tvalid || (xfer && m_tlast);

    always_comb
    begin
        chars_next = chars_reg;
        rem_next   = rem_reg;
        if (load)
        begin
            chars_next = grp.chars;
            rem_next   = grp.cnt;
        end
        else if (xfer)
        begin
            chars_next = {8'd0, chars_reg[3:1]};
            rem_next   = rem_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= 3'd0;
        end
        else
        begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chars_reg <= chars_next;
    end

endmodule

FILE: rtl/greek_byte_transliterator_top.sv
// Greek byte transliterator: each input transfer carries one ISO 8859-7 code in
// s_tdata (s_tuser high marks end of stream and flushes a held M/N/m/n); the block
// answers with zero to four Latin bytes on the master side, one byte per transfer,
// with m_tlast on the final byte of each input. Input passes a one-entry input
// register, then the table decode, into a four-byte result register that shifts
// out one byte per cycle while m_tready is high. The output shifter is the limit:
// a new input is taken every cycle while each result is at most one byte and
// m_tready is high, and the first byte of an input passes the input register and
// then the result register before it is presented on the master side.
module greek_byte_transliterator_top
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    input  logic       s_tuser,   // end_of_stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_char
    output logic       m_tlast    // last
);
    import gxl_pkg::*;

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       eos_reg;
    pend_t      pend_reg;
    pend_t      pend_next;
    pend_t      dec_pend;
    xl_group_t  grp;
    logic       free;
    logic       fire;

    assign fire     = in_valid_reg && free;
    assign s_tready = !in_valid_reg || fire;

    gxl_decode u_decode
    (
        .in_byte   (in_byte_reg),
        .eos       (eos_reg),
        .pend      (pend_reg),
        .grp       (grp),
        .pend_next (dec_pend)
    );

    gxl_out u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire),
        .grp      (grp),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        pend_next     = pend_reg;
        if (fire)
        begin
            in_valid_next = 1'b0;
            pend_next     = dec_pend;
        end
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            pend_reg     <= PEND_NONE;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            pend_reg     <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            eos_reg     <= s_tuser;
        end
    end

`ifndef SYNTHESIS
    a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && eos_reg |=> pend_reg == PEND_NONE)
        else $error("held letter survives end of stream");

    a_in_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !fire |=> in_valid_reg && $stable(in_byte_reg) && $stable(eos_reg))
        else $error("stalled input item lost");

    a_held_release: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !eos_reg && pend_reg != PEND_NONE |=> m_tvalid)
        else $error("held letter dropped without output");
`endif

endmodule

FILE: tb/greek_byte_transliterator_top_tb.sv
`timescale 1ns / 100ps

module greek_byte_transliterator_top_tb;

    import gxl_pkg::*;

    localparam logic [7:0] CODE_UM          = 8'd204;
    localparam logic [7:0] CODE_UN          = 8'd205;
    localparam logic [7:0] CODE_LM          = 8'd236;
    localparam logic [7:0] CODE_LN          = 8'd237;
    localparam logic [7:0] CODE_PI_UC       = 8'd208;
    localparam logic [7:0] CODE_PI_LC       = 8'd240;
    localparam logic [7:0] CODE_TAU_UC      = 8'd212;
    localparam logic [7:0] CODE_TAU_LC      = 8'd244;
    localparam logic [7:0] CODE_ALPHA_TONOS = 8'd182;
    localparam logic [7:0] CODE_ANO_TELEIA  = 8'd183;
    localparam logic [7:0] CODE_UNASSIGNED  = 8'd210;
    localparam logic [7:0] CODE_IOTA_DT     = 8'd192;
    localparam logic [7:0] CODE_OMEGA_TONOS = 8'd254;
    localparam logic [7:0] CODE_NO_ENTRY    = 8'd255;

    localparam int RANDOM_ITEMS   = 305;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;

    typedef struct {
        logic [7:0]      code;
        logic            eos;
        int              typed_cnt;   // -1: expectation comes from the predictor
        logic [3:0][7:0] typed;       // typed[0] leaves first
    } stim_row_t;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } out_byte_t;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = '0;
    logic       s_tuser  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    string latin_spelling [73] = '{
        "'A", "", "'E", "'H", "'I", "", "'O", "", "'Y", "'W",
        "i'\"", "A", "V", "G", "D", "E", "Z", "H", "8", "I",
        "K", "L", "M", "N", "KS", "O", "P", "R", "", "S",
        "T", "Y", "F", "X", "PS", "W", "I\"", "Y\"", "a'", "e'",
        "h'", "i'", "y'\"", "a", "v", "g", "d", "e", "z", "h",
        "8", "i", "k", "l", "m", "n", "ks", "o", "p", "r",
        "s", "s", "t", "y", "f", "x", "ps", "w", "i\"", "y\"",
        "o'", "y'", "w'"
    };

    pend_t      held_letter = PEND_NONE;
    logic [7:0] step_bytes [$];
    out_byte_t  expected_out [$];
    out_byte_t  head;
    stim_row_t  directed_rows [$];

    bit steady_send = 1'b0;
    int errors = 0;
    int items_sent = 0;
    int bytes_checked = 0;
    int pair_merges = 0;
    int held_flushes = 0;
    int idle_cycles = 0;

    greek_byte_transliterator_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] held_char(input pend_t p);
        case (p)
            PEND_UM: return "M";
            PEND_UN: return "N";
            PEND_LM: return "m";
            PEND_LN: return "n";
            default: return 8'h00;
        endcase
    endfunction

    // byte seen with no letter held
    function automatic void emit_fresh(input logic [7:0] b);
        string s;
        int k;
        case (b)
            CODE_UM: held_letter = PEND_UM;
            CODE_UN: held_letter = PEND_UN;
            CODE_LM: held_letter = PEND_LM;
            CODE_LN: held_letter = PEND_LN;
            default:
            begin
                if (b < TableBase || b == CODE_NO_ENTRY)
                    step_bytes.push_back(b);
                else
                begin
                    s = latin_spelling[b - TableBase];
                    if (s.len() == 0)
                        step_bytes.push_back(b);
                    else
                        for (k = 0; k < s.len(); k++)
                            step_bytes.push_back(s[k]);
                end
            end
        endcase
    endfunction

    function automatic void add_row(input logic [7:0] code, input logic eos,
                                    input int cnt = -1,
                                    input logic [7:0] b0 = 8'h00,
                                    input logic [7:0] b1 = 8'h00);
        stim_row_t r;
        r.code = code;
        r.eos = eos;
        r.typed_cnt = cnt;
        r.typed = {16'h0000, b1, b0};
        directed_rows.push_back(r);
    endfunction

    task automatic send_item(input stim_row_t row);
        int gap;
        int i;
        pend_t prev;
        bit is_pi;
        bit is_tau;
        out_byte_t ob;
        gap = steady_send ? 0 : idle_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= row.code;
        s_tuser  <= row.eos;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);

        // lookahead on the held letter
        step_bytes = {};
        if (row.eos)
        begin
            if (held_letter != PEND_NONE)
            begin
                step_bytes.push_back(held_char(held_letter));
                held_flushes++;
            end
            held_letter = PEND_NONE;
        end
        else if (held_letter == PEND_NONE)
            emit_fresh(row.code);
        else
        begin
            is_pi  = (row.code == CODE_PI_UC || row.code == CODE_PI_LC);
            is_tau = (row.code == CODE_TAU_UC || row.code == CODE_TAU_LC);
            prev = held_letter;
            held_letter = PEND_NONE;
            if (prev == PEND_UM && is_pi)
                step_bytes.push_back("B");
            else if (prev == PEND_LM && is_pi)
                step_bytes.push_back("b");
            else if (prev == PEND_UN && is_tau)
                step_bytes.push_back("D");
            else if (prev == PEND_LN && is_tau)
                step_bytes.push_back("d");
            else
            begin
                step_bytes.push_back(held_char(prev));
                emit_fresh(row.code);
            end
            if (step_bytes.size() == 1 && (is_pi || is_tau) &&
                step_bytes[0] != row.code && step_bytes[0] != held_char(prev))
                pair_merges++;
        end

        if (row.typed_cnt >= 0)
        begin
            step_bytes = {};
            for (i = 0; i < row.typed_cnt; i++)
                step_bytes.push_back(row.typed[i]);
        end

        for (i = 0; i < step_bytes.size(); i++)
        begin
            ob.ch = step_bytes[i];
            ob.last = (i == step_bytes.size() - 1);
            expected_out.push_back(ob);
        end
        items_sent++;
    endtask

    // output sink with random backpressure
    initial
    begin
        int run;
        int stall;
        forever
        begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
            stall = idle_len();
            m_tready <= 1'b1;
            repeat (run) @(posedge clk);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            bytes_checked++;
            if (expected_out.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected transfer, out_char %h last %b",
                         $time, m_tdata, m_tlast);
            end
            else
            begin
                head = expected_out.pop_front();
                if (m_tdata !== head.ch || m_tlast !== head.last)
                begin
                    errors++;
                    $display("%0t: out_char expected %h actual %h, last expected %b actual %b",
                             $time, head.ch, m_tdata, head.last, m_tlast);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("greek_byte_transliterator_top_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        int n;
        int r;
        int n_directed;
        bit last_was_hold;
        stim_row_t row;

        add_row(8'hFF, 1'b1, 0);
        add_row(8'h00, 1'b0, 1, 8'h00);
        add_row(8'd181, 1'b0, 1, 8'd181);
        add_row(CODE_ALPHA_TONOS, 1'b0, 2, "'", "A");
        add_row(CODE_ANO_TELEIA, 1'b0, 1, CODE_ANO_TELEIA);
        add_row(CODE_UNASSIGNED, 1'b0, 1, CODE_UNASSIGNED);
        add_row(CODE_NO_ENTRY, 1'b0, 1, CODE_NO_ENTRY);
        add_row(CODE_IOTA_DT, 1'b0);
        add_row(CODE_OMEGA_TONOS, 1'b0);
        add_row(CODE_UM, 1'b0, 0);
        add_row(CODE_PI_UC, 1'b0, 1, "B");
        add_row(CODE_LM, 1'b0, 0);
        add_row(CODE_PI_LC, 1'b0, 1, "b");
        add_row(CODE_UN, 1'b0, 0);
        add_row(CODE_TAU_UC, 1'b0, 1, "D");
        add_row(CODE_LN, 1'b0, 0);
        add_row(CODE_TAU_LC, 1'b0, 1, "d");
        add_row(CODE_UM, 1'b0, 0);
        add_row(CODE_UN, 1'b0, 1, "M");
        add_row(CODE_LN, 1'b0, 1, "N");
        add_row(CODE_IOTA_DT, 1'b0);
        add_row(CODE_LM, 1'b0, 0);
        add_row(8'hA5, 1'b1, 1, "m");
        add_row(CODE_UN, 1'b0, 0);
        add_row(CODE_PI_LC, 1'b0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i]);
        n_directed = items_sent;

        // let the block drain before the random part
        s_tvalid <= 1'b0;
        while (expected_out.size() != 0)
            @(posedge clk);

        last_was_hold = 1'b0;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady_send = (n >= 100 && n < 140);
            if (n == RANDOM_ITEMS / 2)
            begin
                s_tvalid <= 1'b0;
                while (expected_out.size() != 0)
                    @(posedge clk);
            end
            r = $urandom_range(0, 99);
            row.eos = 1'b0;
            row.typed_cnt = -1;
            row.typed = '0;
            if ((last_was_hold && r < 55) || (!last_was_hold && r < 7))
            begin
                case ($urandom_range(0, 3))
                    0: row.code = CODE_PI_UC;
                    1: row.code = CODE_PI_LC;
                    2: row.code = CODE_TAU_UC;
                    default: row.code = CODE_TAU_LC;
                endcase
            end
            else if (r < 25)
            begin
                case ($urandom_range(0, 3))
                    0: row.code = CODE_UM;
                    1: row.code = CODE_UN;
                    2: row.code = CODE_LM;
                    default: row.code = CODE_LN;
                endcase
            end
            else if (r < 72)
                row.code = 8'($urandom_range(TableBase, 255));
            else if (r < 92)
                row.code = 8'($urandom_range(0, 255));
            else
            begin
                row.code = 8'($urandom_range(0, 255));
                row.eos = 1'b1;
            end
            last_was_hold = !row.eos && (row.code == CODE_UM || row.code == CODE_UN ||
                                         row.code == CODE_LM || row.code == CODE_LN);
            send_item(row);
        end
        steady_send = 1'b0;

        // flush anything still held
        row.code = 8'($urandom_range(0, 255));
        row.eos = 1'b1;
        row.typed_cnt = -1;
        send_item(row);
        s_tvalid <= 1'b0;

        while (expected_out.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_out.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected bytes never came", $time, expected_out.size());
        end

        $display("Covered %0d input transfers (%0d directed), %0d output bytes checked,",
                 items_sent, n_directed, bytes_checked);
        $display("%0d held-letter pairs merged, %0d held letters flushed at stream end",
                 pair_merges, held_flushes);
        if (errors == 0)
            $display("greek_byte_transliterator_top_tb: done, clean");
        else
            $display("greek_byte_transliterator_top_tb: done, errors");
        $finish;
    end

endmodule

FILE: files.f
rtl/gxl_pkg.sv
rtl/gxl_decode.sv
rtl/gxl_out.sv
rtl/greek_byte_transliterator_top.sv
tb/greek_byte_transliterator_top_tb.sv
